// ===== hdl/idle_sleep_mode_controller_top_defines.svh =====
// assertion macros for the idle / sleep mode controller
`ifndef IDLE_SLEEP_MODE_CONTROLLER_TOP_DEFINES_SVH
`define IDLE_SLEEP_MODE_CONTROLLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ISMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ismc check failed");

// antecedent implies consequent in the next cycle
`define ISMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ismc check failed");

`else

`define ISMC_ASSERT_IMP(lbl, ante, cons)
`define ISMC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/ismc_pkg.sv =====
package ismc_pkg;

  localparam int unsigned CNT_W  = 12;
  localparam int unsigned LINK_W = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX   = 12'd4095;
  localparam logic [LINK_W-1:0] MAX_LINKS = 3'd4;

  // event codes
  localparam logic [3:0] OP_TICK        = 4'd0;
  localparam logic [3:0] OP_ACTIVITY    = 4'd1;
  localparam logic [3:0] OP_LINK_UP     = 4'd2;
  localparam logic [3:0] OP_LINK_DOWN   = 4'd3;
  localparam logic [3:0] OP_MODULE_ON   = 4'd4;
  localparam logic [3:0] OP_MODULE_OFF  = 4'd5;
  localparam logic [3:0] OP_SET_INHIBIT = 4'd6;
  localparam logic [3:0] OP_AWAKE_EXP   = 4'd7;
  localparam logic [3:0] OP_LIGHT_WAKE  = 4'd8;
  localparam logic [3:0] OP_START       = 4'd9;

  // commands
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_LIGHT      = 3'd1;
  localparam logic [2:0] CMD_DEEP       = 3'd2;
  localparam logic [2:0] CMD_STOP_INIT  = 3'd3;
  localparam logic [2:0] CMD_STOP_AWAKE = 3'd4;

  // mode codes as seen on the result word
  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_LIGHT  = 2'd1;
  localparam logic [1:0] MODE_DEEP   = 2'd2;
  localparam logic [1:0] MODE_AWAKE  = 2'd3;

  // wake causes
  localparam logic [1:0] CAUSE_TIMER = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_LIGHT_IDLE    = 2'd0;
  localparam logic [1:0] REG_LIGHT_REENTER = 2'd1;
  localparam logic [1:0] REG_DEEP_IDLE     = 2'd2;

  localparam logic [CNT_W-1:0] LIGHT_IDLE_RST    = 12'd10;
  localparam logic [CNT_W-1:0] LIGHT_REENTER_RST = 12'd3;
  localparam logic [CNT_W-1:0] DEEP_IDLE_RST     = 12'd60;

  typedef enum logic [3:0] {
    MS_ACTIVE = 4'b0001,
    MS_LIGHT  = 4'b0010,
    MS_DEEP   = 4'b0100,
    MS_AWAKE  = 4'b1000
  } mode_st_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] link_count;
    logic       tt_initializing;
    logic       inhibit_value;
    logic [1:0] wake_cause;
    logic       tt_powered_now;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  command;
    logic        wake_pin_enable;
    logic [11:0] idle_seconds;
    logic [11:0] deep_idle_seconds;
    logic [1:0]  cause_seen;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] light_idle;
    logic [CNT_W-1:0] light_reenter;
    logic [CNT_W-1:0] deep_idle;
  } cfg_t;

  typedef struct packed {
    mode_st_t          mode;
    logic [CNT_W-1:0]  idle_cnt;
    logic [CNT_W-1:0]  deep_cnt;
    logic [LINK_W-1:0] link_cnt;
    logic              powered;
    logic              inhibit;
    logic              just_woke;
    logic              init_issued;
    logic [1:0]        cause;
  } state_t;

  localparam state_t ST_RESET = '{
    mode:        MS_ACTIVE,
    idle_cnt:    '0,
    deep_cnt:    '0,
    link_cnt:    '0,
    powered:     1'b0,
    inhibit:     1'b0,
    just_woke:   1'b0,
    init_issued: 1'b0,
    cause:       2'd0
  };

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 12'd1;
  endfunction

  function automatic logic [1:0] mode_code(input mode_st_t m);
    logic [1:0] c;
    unique case (m)
      MS_ACTIVE: c = MODE_ACTIVE;
      MS_LIGHT:  c = MODE_LIGHT;
      MS_DEEP:   c = MODE_DEEP;
      MS_AWAKE:  c = MODE_AWAKE;
      default:   c = MODE_ACTIVE;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/ismc_cfg.sv =====
module ismc_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [11:0]            cfg_wdata,
  output ismc_pkg::cfg_t         cfg
);

  ismc_pkg::cfg_t cfg_r;
  ismc_pkg::cfg_t cfg_nxt;

  // register write decode, unused index is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        ismc_pkg::REG_LIGHT_IDLE:    cfg_nxt.light_idle    = cfg_wdata;
        ismc_pkg::REG_LIGHT_REENTER: cfg_nxt.light_reenter = cfg_wdata;
        ismc_pkg::REG_DEEP_IDLE:     cfg_nxt.deep_idle     = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_idle    <= ismc_pkg::LIGHT_IDLE_RST;
      cfg_r.light_reenter <= ismc_pkg::LIGHT_REENTER_RST;
      cfg_r.deep_idle     <= ismc_pkg::DEEP_IDLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/ismc_step.sv =====
module ismc_step (
  input  ismc_pkg::state_t    st,
  input  ismc_pkg::cfg_t      cfg,
  input  ismc_pkg::in_word_t  word,
  output ismc_pkg::state_t    st_nxt,
  output ismc_pkg::out_word_t res
);

  logic [ismc_pkg::CNT_W-1:0]  idle_inc;
  logic [ismc_pkg::CNT_W-1:0]  deep_inc;
  logic [ismc_pkg::CNT_W-1:0]  light_lim;
  logic [ismc_pkg::LINK_W-1:0] link_inc;
  logic [ismc_pkg::LINK_W-1:0] link_dec;
  logic [2:0]                  cmd;

  // saturating counter steps and the light-sleep threshold in force
  assign idle_inc  = ismc_pkg::sat_inc(st.idle_cnt);
  assign deep_inc  = ismc_pkg::sat_inc(st.deep_cnt);
  assign light_lim = st.just_woke ? cfg.light_reenter : cfg.light_idle;
  assign link_inc  = (st.link_cnt < ismc_pkg::MAX_LINKS) ? st.link_cnt + 3'd1 : st.link_cnt;
  assign link_dec  = (st.link_cnt != '0) ? st.link_cnt - 3'd1 : st.link_cnt;

  // event decode and next state
  always_comb begin
    st_nxt = st;
    cmd    = ismc_pkg::CMD_NONE;
    if (word.op == ismc_pkg::OP_START) begin
      // full boot from any mode
      st_nxt         = ismc_pkg::ST_RESET;
      st_nxt.cause   = word.wake_cause;
      st_nxt.powered = word.tt_powered_now;
      st_nxt.mode    = (word.wake_cause == ismc_pkg::CAUSE_TIMER) ?
                       ismc_pkg::MS_AWAKE : ismc_pkg::MS_ACTIVE;
    end else if (st.mode != ismc_pkg::MS_DEEP) begin
      unique case (word.op)
        ismc_pkg::OP_TICK: begin
          if (st.mode == ismc_pkg::MS_ACTIVE || st.mode == ismc_pkg::MS_AWAKE) begin
            st_nxt.idle_cnt = idle_inc;
            if (!st.inhibit && st.mode == ismc_pkg::MS_ACTIVE) begin
              if (word.link_count != '0 || st.powered) begin
                st_nxt.deep_cnt = '0;
                if (!(st.powered && word.tt_initializing) && idle_inc >= light_lim) begin
                  st_nxt.mode = ismc_pkg::MS_LIGHT;
                  cmd         = ismc_pkg::CMD_LIGHT;
                end
              end else begin
                st_nxt.deep_cnt = deep_inc;
                if (deep_inc >= cfg.deep_idle) begin
                  st_nxt.mode = ismc_pkg::MS_DEEP;
                  cmd         = ismc_pkg::CMD_DEEP;
                end
              end
            end
          end
        end
        ismc_pkg::OP_ACTIVITY: begin
          st_nxt.idle_cnt  = '0;
          st_nxt.just_woke = 1'b0;
        end
        ismc_pkg::OP_LINK_UP: begin
          st_nxt.link_cnt = link_inc;
          st_nxt.idle_cnt = '0;
          st_nxt.deep_cnt = '0;
          if (st.mode == ismc_pkg::MS_AWAKE) begin
            // back to active, full init requested only once
            st_nxt.mode = ismc_pkg::MS_ACTIVE;
            if (st.init_issued) begin
              cmd = ismc_pkg::CMD_STOP_AWAKE;
            end else begin
              cmd                = ismc_pkg::CMD_STOP_INIT;
              st_nxt.init_issued = 1'b1;
            end
          end
        end
        ismc_pkg::OP_LINK_DOWN: begin
          st_nxt.link_cnt = link_dec;
          st_nxt.idle_cnt = '0;
        end
        ismc_pkg::OP_MODULE_ON: begin
          st_nxt.powered  = 1'b1;
          st_nxt.idle_cnt = '0;
          st_nxt.deep_cnt = '0;
        end
        ismc_pkg::OP_MODULE_OFF: begin
          st_nxt.powered  = 1'b0;
          st_nxt.idle_cnt = '0;
        end
        ismc_pkg::OP_SET_INHIBIT: begin
          st_nxt.inhibit = word.inhibit_value;
          if (word.inhibit_value) begin
            st_nxt.idle_cnt = '0;
          end
        end
        ismc_pkg::OP_AWAKE_EXP: begin
          // a cached count of zero with live links means the cache lagged
          if (st.link_cnt == '0) begin
            if (word.link_count != '0) begin
              st_nxt.link_cnt = link_inc;
            end else if (!st.inhibit && st.mode == ismc_pkg::MS_AWAKE) begin
              st_nxt.mode = ismc_pkg::MS_DEEP;
              cmd         = ismc_pkg::CMD_DEEP;
            end
          end
        end
        ismc_pkg::OP_LIGHT_WAKE: begin
          if (st.mode == ismc_pkg::MS_LIGHT) begin
            st_nxt.mode      = ismc_pkg::MS_ACTIVE;
            st_nxt.just_woke = 1'b1;
            st_nxt.idle_cnt  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result word from the updated state
  always_comb begin
    res.mode              = ismc_pkg::mode_code(st_nxt.mode);
    res.command           = cmd;
    res.wake_pin_enable   = st_nxt.powered;
    res.idle_seconds      = st_nxt.idle_cnt;
    res.deep_idle_seconds = st_nxt.deep_cnt;
    res.cause_seen        = st_nxt.cause;
  end

endmodule

// ===== hdl/idle_sleep_mode_controller_top.sv =====
// channel   direction  word type            handshake
// in_       input      ismc_pkg::in_word_t  in_valid / in_stall
// out_      output     ismc_pkg::out_word_t out_valid / out_stall
// cfg_      input      12-bit data, 2-bit index, write enable
//
// one word per cycle sustained while out_stall is low; each word passes through the input
// register and then the output register before it appears on out_word.
// the mode and counter state updates as a word moves into the output register.
// reset (synchronous, rst_n low) restores the limits, clears both valid bits and the controller state.
// out_stall holds the output register; in_stall rises only when both
// registers are full and the output is stalled.
`include "idle_sleep_mode_controller_top_defines.svh"

module idle_sleep_mode_controller_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ismc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ismc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [11:0]         cfg_wdata
);

  logic                in_v_r;
  ismc_pkg::in_word_t  in_word_r;
  logic                out_v_r;
  ismc_pkg::out_word_t out_word_r;
  ismc_pkg::state_t    st_r;
  ismc_pkg::state_t    st_nxt;
  ismc_pkg::out_word_t res;
  ismc_pkg::cfg_t      cfg;
  logic                adv;

  ismc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ismc_step u_step (
    .st     (st_r),
    .cfg    (cfg),
    .word   (in_word_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // output register free or draining this cycle
  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  // output register and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      st_r    <= ismc_pkg::ST_RESET;
    end else if (adv) begin
      out_v_r <= in_v_r;
      if (in_v_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

  // checks
  `ISMC_ASSERT_IMP(a_light_cmd_mode, out_v_r && out_word_r.command == ismc_pkg::CMD_LIGHT, out_word_r.mode == ismc_pkg::MODE_LIGHT)
  `ISMC_ASSERT_IMP(a_deep_cmd_mode, out_v_r && out_word_r.command == ismc_pkg::CMD_DEEP, out_word_r.mode == ismc_pkg::MODE_DEEP)
  `ISMC_ASSERT_IMP(a_stall_only_full, in_stall, in_v_r && out_v_r && out_stall)
  `ISMC_ASSERT_NXT(a_activity_clears, in_v_r && adv && in_word_r.op == ismc_pkg::OP_ACTIVITY && st_r.mode != ismc_pkg::MS_DEEP, out_word_r.idle_seconds == '0)

endmodule

// ===== tb/tb_idle_sleep_mode_controller_top.sv =====
module tb_idle_sleep_mode_controller_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ismc_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  ismc_pkg::out_word_t out_word;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [11:0]         cfg_wdata;

  // shared test controls
  logic        idling;
  logic        hold_req;
  int unsigned mismatches;
  int unsigned effective_items;
  int unsigned quiet_cycles;

  // predicted controller state and limits
  logic [1:0]  ctl_mode;
  logic [11:0] ctl_idle;
  logic [11:0] ctl_deep;
  logic [2:0]  ctl_links;
  logic        ctl_powered;
  logic        ctl_inhibit;
  logic        ctl_woke;
  logic        ctl_init_done;
  logic [1:0]  ctl_cause;
  logic [11:0] lim_light;
  logic [11:0] lim_reenter;
  logic [11:0] lim_deep;

  ismc_pkg::out_word_t status_due[$];
  ismc_pkg::out_word_t want;

  idle_sleep_mode_controller_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // status predictor
  // ---------------------------------------------------------------------------

  function automatic logic [11:0] bump_sat(logic [11:0] v);
    return (v == 12'hFFF) ? v : v + 12'd1;
  endfunction

  function automatic void clear_controller();
    ctl_mode      = ismc_pkg::MODE_ACTIVE;
    ctl_idle      = '0;
    ctl_deep      = '0;
    ctl_links     = '0;
    ctl_powered   = 1'b0;
    ctl_inhibit   = 1'b0;
    ctl_woke      = 1'b0;
    ctl_init_done = 1'b0;
    ctl_cause     = '0;
  endfunction

  function automatic ismc_pkg::out_word_t advance_power_fsm(ismc_pkg::in_word_t w);
    ismc_pkg::out_word_t r;
    logic [2:0]          cmd;
    logic [11:0]         lim;
    logic                connected;
    cmd = ismc_pkg::CMD_NONE;
    if (w.op == ismc_pkg::OP_START) begin
      // full boot from any mode
      clear_controller();
      ctl_cause   = w.wake_cause;
      ctl_powered = w.tt_powered_now;
      ctl_mode    = (w.wake_cause == ismc_pkg::CAUSE_TIMER) ?
                    ismc_pkg::MODE_AWAKE : ismc_pkg::MODE_ACTIVE;
    end else if (ctl_mode != ismc_pkg::MODE_DEEP) begin
      case (w.op)
        ismc_pkg::OP_TICK: begin
          if (ctl_mode == ismc_pkg::MODE_ACTIVE || ctl_mode == ismc_pkg::MODE_AWAKE) begin
            ctl_idle = bump_sat(ctl_idle);
            if (!ctl_inhibit && ctl_mode == ismc_pkg::MODE_ACTIVE) begin
              if (w.link_count != 3'd0 || ctl_powered) begin
                ctl_deep = '0;
                if (!(ctl_powered && w.tt_initializing)) begin
                  lim = ctl_woke ? lim_reenter : lim_light;
                  if (ctl_idle >= lim) begin
                    ctl_mode = ismc_pkg::MODE_LIGHT;
                    cmd      = ismc_pkg::CMD_LIGHT;
                  end
                end
              end else begin
                ctl_deep = bump_sat(ctl_deep);
                if (ctl_deep >= lim_deep) begin
                  ctl_mode = ismc_pkg::MODE_DEEP;
                  cmd      = ismc_pkg::CMD_DEEP;
                end
              end
            end
          end
        end
        ismc_pkg::OP_ACTIVITY: begin
          ctl_idle = '0;
          ctl_woke = 1'b0;
        end
        ismc_pkg::OP_LINK_UP: begin
          if (ctl_links < ismc_pkg::MAX_LINKS) ctl_links = ctl_links + 3'd1;
          ctl_idle = '0;
          ctl_deep = '0;
          if (ctl_mode == ismc_pkg::MODE_AWAKE) begin
            ctl_mode = ismc_pkg::MODE_ACTIVE;
            if (ctl_init_done) begin
              cmd = ismc_pkg::CMD_STOP_AWAKE;
            end else begin
              cmd           = ismc_pkg::CMD_STOP_INIT;
              ctl_init_done = 1'b1;
            end
          end
        end
        ismc_pkg::OP_LINK_DOWN: begin
          if (ctl_links != 3'd0) ctl_links = ctl_links - 3'd1;
          ctl_idle = '0;
        end
        ismc_pkg::OP_MODULE_ON: begin
          ctl_powered = 1'b1;
          ctl_idle    = '0;
          ctl_deep    = '0;
        end
        ismc_pkg::OP_MODULE_OFF: begin
          ctl_powered = 1'b0;
          ctl_idle    = '0;
        end
        ismc_pkg::OP_SET_INHIBIT: begin
          ctl_inhibit = w.inhibit_value;
          if (w.inhibit_value) ctl_idle = '0;
        end
        ismc_pkg::OP_AWAKE_EXP: begin
          // a live link not yet counted syncs the cache and keeps us awake
          connected = (ctl_links != 3'd0);
          if (!connected && w.link_count != 3'd0) begin
            if (ctl_links < ismc_pkg::MAX_LINKS) ctl_links = ctl_links + 3'd1;
            connected = 1'b1;
          end
          if (!connected && !ctl_inhibit && ctl_mode == ismc_pkg::MODE_AWAKE) begin
            ctl_mode = ismc_pkg::MODE_DEEP;
            cmd      = ismc_pkg::CMD_DEEP;
          end
        end
        ismc_pkg::OP_LIGHT_WAKE: begin
          if (ctl_mode == ismc_pkg::MODE_LIGHT) begin
            ctl_mode = ismc_pkg::MODE_ACTIVE;
            ctl_woke = 1'b1;
            ctl_idle = '0;
          end
        end
        default: ;
      endcase
    end
    r.mode              = ctl_mode;
    r.command           = cmd;
    r.wake_pin_enable   = ctl_powered;
    r.idle_seconds      = ctl_idle;
    r.deep_idle_seconds = ctl_deep;
    r.cause_seen        = ctl_cause;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [11:0] got, logic [11:0] exp_val);
    if (got !== exp_val) report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // result check first, then prediction of the word accepted on this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_word));
        end else begin
          want = status_due.pop_front();
          check_field("mode", out_word.mode, want.mode);
          check_field("command", out_word.command, want.command);
          check_field("wake_pin_enable", out_word.wake_pin_enable, want.wake_pin_enable);
          check_field("idle_seconds", out_word.idle_seconds, want.idle_seconds);
          check_field("deep_idle_seconds", out_word.deep_idle_seconds,
                      want.deep_idle_seconds);
          check_field("cause_seen", out_word.cause_seen, want.cause_seen);
        end
      end
      if (in_valid && !in_stall) begin
        if (!((ctl_mode == ismc_pkg::MODE_DEEP && in_word.op != ismc_pkg::OP_START) ||
              in_word.op > ismc_pkg::OP_START))
          effective_items++;
        status_due.push_back(advance_power_fsm(in_word));
      end
    end
  end

  // watchdog on cycles with work pending but no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && status_due.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall per word, one long hold on request
  initial begin : result_sink
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = idling ? $urandom_range(0, 19) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ismc_pkg::in_word_t ev(logic [3:0] op, logic [2:0] links, logic init,
                                            logic inh, logic [1:0] cause, logic pwr);
    ismc_pkg::in_word_t w;
    w.op              = op;
    w.link_count      = links;
    w.tt_initializing = init;
    w.inhibit_value   = inh;
    w.wake_cause      = cause;
    w.tt_powered_now  = pwr;
    return w;
  endfunction

  function automatic ismc_pkg::in_word_t rand_word(logic [3:0] op);
    logic [2:0] links;
    links = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(1, 7));
    return ev(op, links, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endfunction

  // offer one word, return at the edge where it is taken
  task automatic send_word(ismc_pkg::in_word_t w);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [11:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ismc_pkg::REG_LIGHT_IDLE:    lim_light   = value;
      ismc_pkg::REG_LIGHT_REENTER: lim_reenter = value;
      ismc_pkg::REG_DEEP_IDLE:     lim_deep    = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [11:0] light, logic [11:0] reenter, logic [11:0] deep);
    drain();
    write_limit(ismc_pkg::REG_LIGHT_IDLE, light);
    write_limit(ismc_pkg::REG_LIGHT_REENTER, reenter);
    write_limit(ismc_pkg::REG_DEEP_IDLE, deep);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // each event at least once from active, plus unknown codes, with reset limits
  task automatic test_every_event();
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(4'd10, 3'd0, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(ev(4'd15, 3'd7, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LIGHT_WAKE, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_ACTIVITY, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_MODULE_ON, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    // powered and initializing: no light sleep
    send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b1, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_SET_INHIBIT, 3'd0, 1'b0, 1'b1, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_TICK, 3'd7, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_SET_INHIBIT, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LINK_UP, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LINK_DOWN, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_MODULE_OFF, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_AWAKE_EXP, 3'd7, 1'b0, 1'b0, 2'd0, 1'b0));
  endtask

  // temporary awake: deep on expiry, link floor, expiry sync, link up
  task automatic test_awake_paths();
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, ismc_pkg::CAUSE_TIMER, 1'b1));
    send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LINK_DOWN, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_AWAKE_EXP, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    // chip is off: everything but start is dropped
    send_word(ev(ismc_pkg::OP_LINK_UP, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, ismc_pkg::CAUSE_TIMER, 1'b0));
    send_word(ev(ismc_pkg::OP_AWAKE_EXP, 3'd3, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LINK_UP, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
  endtask

  // zero limits: light on first second, re-entry after wake, deep on first second
  task automatic test_light_reentry();
    set_limits(12'd0, 12'd0, 12'd0);
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, 2'd2, 1'b1));
    send_word(ev(ismc_pkg::OP_TICK, 3'd2, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_TICK, 3'd2, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_ACTIVITY, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_LIGHT_WAKE, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_TICK, 3'd1, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, 2'd3, 1'b0));
    send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
  endtask

  // both second counters run into their ceiling
  task automatic test_counter_saturation();
    set_limits(ismc_pkg::LIGHT_IDLE_RST, ismc_pkg::LIGHT_REENTER_RST, 12'd4095);
    idling = 1'b0;
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_word(ev(ismc_pkg::OP_SET_INHIBIT, 3'd0, 1'b0, 1'b1, 2'd0, 1'b0));
    repeat (4100) send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_SET_INHIBIT, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    repeat (4096) send_word(ev(ismc_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(ev(ismc_pkg::OP_START, 3'd0, 1'b0, 1'b0, ismc_pkg::CAUSE_TIMER, 1'b0));
    idling = 1'b1;
  endtask

  // long hold on the result side while words keep coming
  task automatic test_backpressure();
    idling   = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_word(rand_word(4'($urandom_range(0, 8))));
    drain();
    idling = 1'b1;
  endtask

  // mostly tick bursts and notifications, some boots and unknown codes
  task automatic test_random_traffic(int unsigned target);
    int unsigned        goal;
    int unsigned        pick;
    int unsigned        n;
    logic [2:0]         links;
    ismc_pkg::in_word_t w;
    goal = effective_items + target;
    while (effective_items < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        n     = $urandom_range(1, 8);
        links = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(1, 7));
        repeat (n) begin
          w                 = rand_word(ismc_pkg::OP_TICK);
          w.link_count      = links;
          w.tt_initializing = ($urandom_range(0, 5) == 0);
          send_word(w);
        end
      end else if (pick < 18) begin
        w               = rand_word(4'($urandom_range(1, 8)));
        w.inhibit_value = ($urandom_range(0, 3) == 0);
        send_word(w);
      end else if (pick == 18) begin
        send_word(rand_word(ismc_pkg::OP_START));
      end else begin
        send_word(rand_word(4'($urandom_range(10, 15))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_word         = '0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    idling          = 1'b1;
    hold_req        = 1'b0;
    mismatches      = 0;
    effective_items = 0;
    quiet_cycles    = 0;
    lim_light       = ismc_pkg::LIGHT_IDLE_RST;
    lim_reenter     = ismc_pkg::LIGHT_REENTER_RST;
    lim_deep        = ismc_pkg::DEEP_IDLE_RST;
    clear_controller();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_every_event();
    test_awake_paths();
    test_light_reentry();
    test_counter_saturation();
    test_backpressure();

    set_limits(ismc_pkg::LIGHT_IDLE_RST, ismc_pkg::LIGHT_REENTER_RST,
               ismc_pkg::DEEP_IDLE_RST);
    test_random_traffic(400);
    set_limits(12'd2, 12'd1, 12'd4);
    idling = 1'b0;
    test_random_traffic(400);
    idling = 1'b1;
    set_limits(12'd0, 12'd0, 12'd0);
    test_random_traffic(300);
    set_limits(12'd6, 12'd3, 12'd15);
    test_random_traffic(500);
    set_limits(12'd4095, 12'd3600, 12'd4095);
    test_random_traffic(300);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
